FILE: rtl/bsfr_pkg.sv
// Shared constants, codes and types for the byte-stuffed frame receiver.
`default_nettype none

package bsfr_pkg;

   // Frame capacity in payload bytes
   localparam int unsigned MAX_FRAME_BYTES = 4096;
   localparam int unsigned COUNT_WIDTH = $clog2(MAX_FRAME_BYTES + 1);

   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned STATUS_WIDTH = 3;
   localparam int unsigned BYTE_INDEX_WIDTH = 12;
   localparam int unsigned FRAME_LENGTH_WIDTH = 13;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_CODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_CODE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_CODE = 2'd2;

   localparam logic [BYTE_WIDTH-1:0] START_CODE_RESET = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] END_CODE_RESET = 8'h3F;
   localparam logic [BYTE_WIDTH-1:0] ESCAPE_CODE_RESET = 8'h2F;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_NONE = 3'd0,
      STATUS_PAYLOAD = 3'd1,
      STATUS_DONE = 3'd2,
      STATUS_DOUBLE_START = 3'd3,
      STATUS_STRAY_END = 3'd4,
      STATUS_OUTSIDE = 3'd5,
      STATUS_OVERFLOW = 3'd6
   } status_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] start_code;
      logic [BYTE_WIDTH-1:0] end_code;
      logic [BYTE_WIDTH-1:0] escape_code;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic [BYTE_INDEX_WIDTH-1:0] byte_index;
      logic [FRAME_LENGTH_WIDTH-1:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/bsfr_csr.sv
// Register file holding the start, end and escape codes.
`default_nettype none

module bsfr_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [bsfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready,
   output bsfr_pkg::cfg_type cfg
);
   import bsfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic write_en;

   assign index = csr_paddr[CSR_ADDR_WIDTH-1:CSR_ADDR_WIDTH-CSR_INDEX_WIDTH];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_START_CODE: cfg_in.start_code = csr_pwdata[BYTE_WIDTH-1:0];
            CSR_END_CODE: cfg_in.end_code = csr_pwdata[BYTE_WIDTH-1:0];
            CSR_ESCAPE_CODE: cfg_in.escape_code = csr_pwdata[BYTE_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_START_CODE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.start_code);
         CSR_END_CODE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.end_code);
         CSR_ESCAPE_CODE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.escape_code);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code <= START_CODE_RESET;
         cfg_ff.end_code <= END_CODE_RESET;
         cfg_ff.escape_code <= ESCAPE_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bsfr_decode.sv
// Framing state and per-byte decode: escape, start, end and data handling.
`default_nettype none

module bsfr_decode (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire logic [bsfr_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  wire bsfr_pkg::cfg_type cfg,
   output bsfr_pkg::result_type result
);
   import bsfr_pkg::*;

   logic escape_pending_ff, escape_pending_in;
   logic in_frame_ff, in_frame_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic is_data;

   always_comb begin
      result.status = STATUS_NONE;
      result.payload_byte = '0;
      result.byte_index = '0;
      result.frame_length = '0;
      escape_pending_in = escape_pending_ff;
      in_frame_in = in_frame_ff;
      byte_count_in = byte_count_ff;
      is_data = 1'b0;

      // escape beats start, start beats end when codes collide
      if (escape_pending_ff) begin
         escape_pending_in = 1'b0;
         is_data = 1'b1;
      end else if (rx_byte == cfg.escape_code) begin
         escape_pending_in = 1'b1;
      end else if (rx_byte == cfg.start_code) begin
         if (in_frame_ff) begin
            result.status = STATUS_DOUBLE_START;
            in_frame_in = 1'b0;
         end else begin
            in_frame_in = 1'b1;
         end
         byte_count_in = '0;
      end else if (rx_byte == cfg.end_code) begin
         if (in_frame_ff) begin
            result.status = STATUS_DONE;
            result.frame_length = FRAME_LENGTH_WIDTH'(byte_count_ff);
         end else begin
            result.status = STATUS_STRAY_END;
         end
         in_frame_in = 1'b0;
         byte_count_in = '0;
      end else begin
         is_data = 1'b1;
      end

      if (is_data) begin
         if (!in_frame_ff) begin
            result.status = STATUS_OUTSIDE;
            in_frame_in = 1'b0;
            byte_count_in = '0;
         end else if (byte_count_ff >= COUNT_WIDTH'(MAX_FRAME_BYTES)) begin
            // drop the frame once it is full
            result.status = STATUS_OVERFLOW;
            in_frame_in = 1'b0;
            byte_count_in = '0;
         end else begin
            result.status = STATUS_PAYLOAD;
            result.payload_byte = rx_byte;
            result.byte_index = BYTE_INDEX_WIDTH'(byte_count_ff);
            byte_count_in = byte_count_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         byte_count_ff <= '0;
      end else if (step) begin
         escape_pending_ff <= escape_pending_in;
         in_frame_ff <= in_frame_in;
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/byte_stuffed_frame_receiver.sv
// Top level of the byte-stuffed frame receiver: input stage, decode and result stage.
`default_nettype none

// Receives one raw link byte per request and returns exactly one result per
// byte: a status (none, payload, frame done or one of four errors) with the
// decoded payload byte and its index, or the finished frame's length. The
// start, end and escape codes are set through the csr_ port (index 0, 1, 2 at
// byte addresses 0, 4, 8) and should be changed only while no request is in
// flight. A request is registered, decoded against the frame state and written
// to the result register. One request is taken every cycle while the results
// are taken; the frame state is updated as each request advances, which
// keeps that rate. A stalled result holds both stages without losing a byte.
module byte_stuffed_frame_receiver (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [bsfr_pkg::BYTE_WIDTH-1:0] req_rx_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [bsfr_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [bsfr_pkg::BYTE_WIDTH-1:0] rsp_payload_byte,
   output logic [bsfr_pkg::BYTE_INDEX_WIDTH-1:0] rsp_byte_index,
   output logic [bsfr_pkg::FRAME_LENGTH_WIDTH-1:0] rsp_frame_length,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [bsfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready
);
   import bsfr_pkg::*;

   cfg_type cfg;
   result_type result;
   result_type out_result_ff;
   logic in_valid_ff;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic out_valid_ff;
   logic advance;

   bsfr_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   bsfr_decode u_decode (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .rx_byte(in_byte_ff),
      .cfg(cfg),
      .result(result)
   );

   // move the registered request into the result stage when it is free
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_result_ff.status;
   assign rsp_payload_byte = out_result_ff.payload_byte;
   assign rsp_byte_index = out_result_ff.byte_index;
   assign rsp_frame_length = out_result_ff.frame_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: sim/bsfr_frame_checker.sv
// Scoreboard for the byte-stuffed frame receiver: predicts every result and compares.
`timescale 1ns / 100ps

module bsfr_frame_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic [bsfr_pkg::BYTE_WIDTH-1:0] req_rx_byte,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic [bsfr_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  wire logic [bsfr_pkg::BYTE_WIDTH-1:0] rsp_payload_byte,
   input  wire logic [bsfr_pkg::BYTE_INDEX_WIDTH-1:0] rsp_byte_index,
   input  wire logic [bsfr_pkg::FRAME_LENGTH_WIDTH-1:0] rsp_frame_length,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [bsfr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [bsfr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  wire logic csr_pready,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned result_count,
   output logic [7:0] status_seen
);
   import bsfr_pkg::*;

   localparam int unsigned MAX_PRINTED = 100;

   cfg_type codes;
   logic escape_pending;
   logic in_frame;
   logic [COUNT_WIDTH-1:0] byte_count;
   result_type expected_results [$];
   int unsigned mismatch_count = 0;
   int unsigned results_checked = 0;
   logic [7:0] statuses_hit = '0;

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
      status_seen = '0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   function automatic void abandon_frame();
      escape_pending = 1'b0;
      in_frame = 1'b0;
      byte_count = '0;
   endfunction

   // Advance the frame state by one link byte and return the result it causes.
   function automatic result_type decode_rx_byte(input logic [BYTE_WIDTH-1:0] rx);
      result_type r;
      logic is_data;
      r = '0;
      r.status = STATUS_NONE;
      is_data = 1'b0;
      if (escape_pending) begin
         escape_pending = 1'b0;
         is_data = 1'b1;
      end else if (rx == codes.escape_code) begin
         escape_pending = 1'b1;
      end else if (rx == codes.start_code) begin
         if (in_frame) begin
            r.status = STATUS_DOUBLE_START;
            abandon_frame();
         end else begin
            in_frame = 1'b1;
            byte_count = '0;
         end
      end else if (rx == codes.end_code) begin
         if (in_frame) begin
            r.status = STATUS_DONE;
            r.frame_length = byte_count;
            in_frame = 1'b0;
            byte_count = '0;
         end else begin
            r.status = STATUS_STRAY_END;
            abandon_frame();
         end
      end else begin
         is_data = 1'b1;
      end

      if (is_data) begin
         if (!in_frame) begin
            r.status = STATUS_OUTSIDE;
            abandon_frame();
         end else if (byte_count >= COUNT_WIDTH'(MAX_FRAME_BYTES)) begin
            r.status = STATUS_OVERFLOW;
            abandon_frame();
         end else begin
            r.status = STATUS_PAYLOAD;
            r.payload_byte = rx;
            r.byte_index = byte_count[BYTE_INDEX_WIDTH-1:0];
            byte_count = byte_count + 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         codes.start_code = START_CODE_RESET;
         codes.end_code = END_CODE_RESET;
         codes.escape_code = ESCAPE_CODE_RESET;
         abandon_frame();
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_INDEX_WIDTH+1:2])
               CSR_START_CODE: codes.start_code = csr_pwdata[BYTE_WIDTH-1:0];
               CSR_END_CODE: codes.end_code = csr_pwdata[BYTE_WIDTH-1:0];
               CSR_ESCAPE_CODE: codes.escape_code = csr_pwdata[BYTE_WIDTH-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            results_checked++;
            statuses_hit[rsp_status] = 1'b1;
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request waiting", '0, 32'(rsp_status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(want.payload_byte),
                                  32'(rsp_payload_byte));
               if (rsp_byte_index !== want.byte_index)
                  report_mismatch("byte_index", 32'(want.byte_index), 32'(rsp_byte_index));
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(want.frame_length),
                                  32'(rsp_frame_length));
            end
         end

         if (req_valid && req_ready)
            expected_results.push_back(decode_rx_byte(req_rx_byte));
      end

      fail_count <= mismatch_count;
      pending_count <= expected_results.size();
      result_count <= results_checked;
      status_seen <= statuses_hit;
   end

endmodule

FILE: sim/tb_byte_stuffed_frame_receiver.sv
// Testbench top for the byte-stuffed frame receiver: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_receiver;
   import bsfr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned LONG_HOLD = 400;
   localparam int unsigned MAX_GAP = 19;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [BYTE_WIDTH-1:0] req_rx_byte;
   logic rsp_valid;
   logic rsp_ready;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [BYTE_WIDTH-1:0] rsp_payload_byte;
   logic [BYTE_INDEX_WIDTH-1:0] rsp_byte_index;
   logic [FRAME_LENGTH_WIDTH-1:0] rsp_frame_length;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned result_count;
   logic [7:0] status_seen;

   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   int unsigned code_settings = 1;
   int unsigned long_holds = 0;
   logic sender_burst = 1'b0;
   cfg_type cur_codes;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_stuffed_frame_receiver i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_frame_length(rsp_frame_length),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   bsfr_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_frame_length(rsp_frame_length),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .status_seen     (status_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until it is taken.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] rx);
      int unsigned gap;
      if ($urandom_range(0, 63) == 0)
         sender_burst = ~sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (!(req_valid && req_ready));
      requests_sent++;
   endtask

   // Escape the byte where it collides with a code, and now and then for no reason.
   task automatic send_payload(input logic [BYTE_WIDTH-1:0] rx);
      if (rx == cur_codes.start_code || rx == cur_codes.end_code ||
          rx == cur_codes.escape_code || $urandom_range(0, 9) == 0)
         send_byte(cur_codes.escape_code);
      send_byte(rx);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_codes(input logic [BYTE_WIDTH-1:0] start_code,
                              input logic [BYTE_WIDTH-1:0] end_code,
                              input logic [BYTE_WIDTH-1:0] escape_code);
      logic [BYTE_WIDTH-1:0] values [3];
      logic [CSR_INDEX_WIDTH-1:0] indexes [3];
      values = '{start_code, end_code, escape_code};
      indexes = '{CSR_START_CODE, CSR_END_CODE, CSR_ESCAPE_CODE};
      for (int i = 0; i < 3; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {indexes[i], 2'b00};
         // upper bits are don't-care; fill them to catch missing masking
         csr_pwdata <= {24'($urandom()), values[i]};
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_codes.start_code = start_code;
      cur_codes.end_code = end_code;
      cur_codes.escape_code = escape_code;
      code_settings++;
   endtask

   // Mostly well-formed frames with random content; the rest is noise and broken frames.
   task automatic send_random_traffic(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned len;
      int unsigned pick;
      stop_at = requests_sent + n_items;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            send_byte(cur_codes.start_code);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            repeat (len) send_payload(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 19);
            if (pick < 16)
               send_byte(cur_codes.end_code);
            else if (pick < 18)
               send_byte(cur_codes.start_code);
         end else begin
            case ($urandom_range(0, 3))
               0: send_byte(8'($urandom_range(0, 255)));
               1: send_byte(cur_codes.end_code);
               2: begin
                  send_byte(cur_codes.escape_code);
                  send_byte(8'($urandom_range(0, 255)));
               end
               default: send_byte(cur_codes.start_code);
            endcase
         end
      end
   endtask

   // Receiver: random stalls per result, bursts without stalls, and two long hold-offs.
   initial begin : result_sink
      int unsigned gap;
      int unsigned accepted;
      logic rsp_burst;
      accepted = 0;
      rsp_burst = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (accepted == 300 || accepted == 1100) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_holds++;
         end
         if ($urandom_range(0, 63) == 0)
            rsp_burst = ~rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         accepted++;
      end
   end

   initial begin : stimulus
      logic [BYTE_WIDTH-1:0] directed [$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cur_codes.start_code = START_CODE_RESET;
      cur_codes.end_code = END_CODE_RESET;
      cur_codes.escape_code = ESCAPE_CODE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset codes: stray end, outside data, escaped start outside a frame, empty
      // frame, escaped codes inside a frame, double start, stray end, escaped start in a frame.
      directed = '{END_CODE_RESET, 8'h00, ESCAPE_CODE_RESET, START_CODE_RESET,
                   START_CODE_RESET, END_CODE_RESET, START_CODE_RESET, 8'h00,
                   ESCAPE_CODE_RESET, START_CODE_RESET, ESCAPE_CODE_RESET, END_CODE_RESET,
                   ESCAPE_CODE_RESET, ESCAPE_CODE_RESET, 8'h7F, END_CODE_RESET,
                   START_CODE_RESET, 8'h01, START_CODE_RESET, END_CODE_RESET,
                   START_CODE_RESET, 8'h80, ESCAPE_CODE_RESET, START_CODE_RESET,
                   END_CODE_RESET};
      foreach (directed[i]) send_byte(directed[i]);

      wait_until_idle();
      write_codes(8'h00, 8'hFF, 8'h80);
      send_random_traffic(400);

      // escape and start share a value: escape takes precedence
      wait_until_idle();
      write_codes(8'h10, 8'h11, 8'h10);
      send_random_traffic(100);

      // start and end share a value: start takes precedence
      wait_until_idle();
      write_codes(8'h20, 8'h20, 8'h21);
      send_random_traffic(100);

      wait_until_idle();
      write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      send_random_traffic(400);

      wait_until_idle();
      write_codes(START_CODE_RESET, END_CODE_RESET, ESCAPE_CODE_RESET);
      send_random_traffic(400);

      wait_until_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under %0d code settings, %0d results checked.",
               requests_sent, code_settings, result_count);
      $display("Status codes seen (bit per code): %b; long stalls %0d.",
               status_seen, long_holds);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
